/* hdl/assert_macros.svh */
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hpcr assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("hpcr assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hdl/hpcr_pkg.sv */
// Widths, constants and types for the hex position to cube rounding block.
package hpcr_pkg;

   localparam int COORD_WIDTH      = 16;
   localparam int FRAC_BITS        = 16;
   localparam int POS_WIDTH        = 32;
   localparam int CSR_WIDTH        = 32;
   localparam int CSR_ADDR_WIDTH   = 2;
   localparam int NUM_STAGES       = 6;

   localparam int DIFF_WIDTH       = POS_WIDTH + 1;
   localparam int SCALE_PROD_WIDTH = DIFF_WIDTH + CSR_WIDTH + 1;
   localparam int SCALE_WIDTH      = COORD_WIDTH + FRAC_BITS + 2;
   localparam int MAT_PROD_WIDTH   = SCALE_WIDTH + FRAC_BITS + 1;
   localparam int FRAC_WIDTH       = SCALE_WIDTH + 2;
   localparam int INT_WIDTH        = FRAC_WIDTH - FRAC_BITS + 1;
   localparam int ERR_WIDTH        = FRAC_BITS;
   localparam int REBUILD_WIDTH    = INT_WIDTH + 1;

   // matrix constants, rounded to nearest from a 32-bit fraction
   localparam logic [63:0] K32_SQRT3_3    = 64'd2479700524;
   localparam logic [63:0] K32_THIRD      = 64'd1431655765;
   localparam logic [63:0] K32_TWO_THIRDS = 64'd2863311531;
   localparam logic [63:0] RND_ADD        = 64'd1 << (31 - FRAC_BITS);
   localparam logic [63:0] KQ_SQRT3_3     = (K32_SQRT3_3 + RND_ADD) >> (32 - FRAC_BITS);
   localparam logic [63:0] KQ_THIRD       = (K32_THIRD + RND_ADD) >> (32 - FRAC_BITS);
   localparam logic [63:0] KQ_TWO_THIRDS  = (K32_TWO_THIRDS + RND_ADD) >> (32 - FRAC_BITS);
   localparam logic [FRAC_BITS-1:0] K_SQRT3_3    = KQ_SQRT3_3[FRAC_BITS-1:0];
   localparam logic [FRAC_BITS-1:0] K_THIRD      = KQ_THIRD[FRAC_BITS-1:0];
   localparam logic [FRAC_BITS-1:0] K_TWO_THIRDS = KQ_TWO_THIRDS[FRAC_BITS-1:0];

   localparam logic [FRAC_BITS-1:0] HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

   localparam logic signed [SCALE_PROD_WIDTH-1:0] SCALE_LIM =
      SCALE_PROD_WIDTH'({(COORD_WIDTH+1+FRAC_BITS){1'b1}});
   localparam logic signed [SCALE_PROD_WIDTH-1:0] SCALE_NEG_LIM = -SCALE_LIM;

   localparam logic signed [REBUILD_WIDTH-1:0] COORD_MAX =
      REBUILD_WIDTH'({(COORD_WIDTH-1){1'b1}});
   localparam logic signed [REBUILD_WIDTH-1:0] COORD_MIN = -COORD_MAX - 1;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_ORIENTATION    = 2'd0,
      CSR_INVERSE_RADIUS = 2'd1,
      CSR_ORIGIN_X       = 2'd2,
      CSR_ORIGIN_Z       = 2'd3
   } csr_index_type;

   typedef enum logic {
      ORIENT_POINTY = 1'b0,
      ORIENT_FLAT   = 1'b1
   } orient_type;

   typedef struct packed {
      logic signed [INT_WIDTH-1:0] value;
      logic [ERR_WIDTH-1:0]        err;
   } round_type;

endpackage

/* hdl/hpcr_if.sv */
// Request and response channel interfaces.
interface hpcr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [hpcr_pkg::POS_WIDTH-1:0]  pos_x;
   logic signed [hpcr_pkg::POS_WIDTH-1:0]  pos_z;
   modport source (output valid, output pos_x, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_z, output ready);
endinterface

interface hpcr_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [hpcr_pkg::COORD_WIDTH-1:0] cube_q;
   logic signed [hpcr_pkg::COORD_WIDTH-1:0] cube_r;
   logic signed [hpcr_pkg::COORD_WIDTH-1:0] cube_s;
   logic                                    clipped;
   modport source (output valid, output cube_q, output cube_r, output cube_s,
                   output clipped, input ready);
   modport sink   (input valid, input cube_q, input cube_r, input cube_s,
                   input clipped, output ready);
endinterface

/* hdl/hpcr_round.sv */
// Round half away from zero with rounding error, one coordinate.
module hpcr_round (
   input  logic signed [hpcr_pkg::FRAC_WIDTH-1:0] frac_in,
   output hpcr_pkg::round_type                    rnd_out
);

   logic                                  neg;
   logic [hpcr_pkg::FRAC_WIDTH-1:0]       mag;
   logic [hpcr_pkg::FRAC_WIDTH:0]         mag_rnd;
   logic [hpcr_pkg::INT_WIDTH-1:0]        n_mag;
   logic [hpcr_pkg::FRAC_BITS-1:0]        frac;
   logic [hpcr_pkg::FRAC_BITS:0]          err_wide;

   always_comb begin
      neg     = frac_in[hpcr_pkg::FRAC_WIDTH-1];
      mag     = neg ? hpcr_pkg::FRAC_WIDTH'(-frac_in) : hpcr_pkg::FRAC_WIDTH'(frac_in);
      mag_rnd = {1'b0, mag} + (hpcr_pkg::FRAC_WIDTH+1)'(hpcr_pkg::HALF);
      n_mag   = mag_rnd[hpcr_pkg::FRAC_WIDTH:hpcr_pkg::FRAC_BITS];
      frac    = mag[hpcr_pkg::FRAC_BITS-1:0];
      // fraction at or above one half rounds up in magnitude
      if (frac[hpcr_pkg::FRAC_BITS-1]) begin
         err_wide = {1'b1, {hpcr_pkg::FRAC_BITS{1'b0}}} - {1'b0, frac};
      end else begin
         err_wide = {1'b0, frac};
      end
      rnd_out.value = neg ? -signed'(n_mag) : signed'(n_mag);
      rnd_out.err   = err_wide[hpcr_pkg::FRAC_BITS-1:0];
   end

endmodule

/* hdl/hex_position_to_cube_round.sv */
// Top level: planar position to rounded hex cube coordinates, six-stage pipeline.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      pos_x, pos_z
//   rsp_ch    out   valid / ready      cube_q, cube_r, cube_s, clipped
//   csr_*     in    csr_we             csr_addr, csr_wdata
//
// Six register stages: origin subtract, radius multiply, scale clamp, matrix
// multiply, rounding, rebuild and clamp. One beat a cycle while rsp_ch.ready is high.
// Each stage stalls only when it is full and the one after it is stalled, so
// bubbles close up behind a held response. Reset clears the stage valid bits
// and the layout registers; there is no clearing pass.
`include "assert_macros.svh"

module hex_position_to_cube_round (
   input  logic                                   clock,
   input  logic                                   reset,
   hpcr_req_if.sink                               req_ch,
   hpcr_rsp_if.source                             rsp_ch,
   input  logic                                   csr_we,
   input  logic [hpcr_pkg::CSR_ADDR_WIDTH-1:0]    csr_addr,
   input  logic [hpcr_pkg::CSR_WIDTH-1:0]         csr_wdata
);

   localparam int NS = hpcr_pkg::NUM_STAGES;

   // layout registers
   hpcr_pkg::orient_type                     orient_ff;
   logic [hpcr_pkg::CSR_WIDTH-1:0]           inv_radius_ff;
   logic signed [hpcr_pkg::POS_WIDTH-1:0]    origin_x_ff;
   logic signed [hpcr_pkg::POS_WIDTH-1:0]    origin_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         orient_ff     <= hpcr_pkg::ORIENT_POINTY;
         inv_radius_ff <= hpcr_pkg::CSR_WIDTH'(1) << hpcr_pkg::FRAC_BITS;
         origin_x_ff   <= '0;
         origin_z_ff   <= '0;
      end else if (csr_we) begin
         case (hpcr_pkg::csr_index_type'(csr_addr))
            hpcr_pkg::CSR_ORIENTATION: begin
               orient_ff <= hpcr_pkg::orient_type'(csr_wdata[0]);
            end
            hpcr_pkg::CSR_INVERSE_RADIUS: begin
               inv_radius_ff <= csr_wdata;
            end
            hpcr_pkg::CSR_ORIGIN_X: begin
               origin_x_ff <= signed'(csr_wdata[hpcr_pkg::POS_WIDTH-1:0]);
            end
            hpcr_pkg::CSR_ORIGIN_Z: begin
               origin_z_ff <= signed'(csr_wdata[hpcr_pkg::POS_WIDTH-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   logic [NS-1:0] stg_valid_ff;
   logic [NS-1:0] stg_valid_in;
   logic [NS:0]   stage_adv;
   logic [NS-1:0] valid_feed;

   always_comb begin
      stage_adv[NS] = rsp_ch.ready;
      for (int k = NS - 1; k >= 0; k--) begin
         stage_adv[k] = !stg_valid_ff[k] || stage_adv[k+1];
      end
      valid_feed = {stg_valid_ff[NS-2:0], req_ch.valid};
      for (int k = 0; k < NS; k++) begin
         stg_valid_in[k] = stage_adv[k] ? valid_feed[k] : stg_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   assign req_ch.ready = stage_adv[0];
   assign rsp_ch.valid = stg_valid_ff[NS-1];

   // stage 1: origin subtract
   logic signed [hpcr_pkg::DIFF_WIDTH-1:0] dx_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         dx_ff <= hpcr_pkg::DIFF_WIDTH'(req_ch.pos_x) - hpcr_pkg::DIFF_WIDTH'(origin_x_ff);
         dz_ff <= hpcr_pkg::DIFF_WIDTH'(req_ch.pos_z) - hpcr_pkg::DIFF_WIDTH'(origin_z_ff);
      end
   end

   // stage 2: scale by the reciprocal radius
   logic signed [hpcr_pkg::SCALE_PROD_WIDTH-1:0] prod_x_ff, prod_z_ff;
   logic signed [hpcr_pkg::CSR_WIDTH:0]          inv_radius_s;

   assign inv_radius_s = signed'({1'b0, inv_radius_ff});

   always_ff @(posedge clock) begin
      if (stage_adv[1]) begin
         prod_x_ff <= dx_ff * inv_radius_s;
         prod_z_ff <= dz_ff * inv_radius_s;
      end
   end

   // stage 3: floor and clamp of the scaled offsets
   logic signed [hpcr_pkg::SCALE_PROD_WIDTH-1:0] shx, shz;
   logic signed [hpcr_pkg::SCALE_WIDTH-1:0]      tx_in, tz_in, tx_ff, tz_ff;
   logic                                         over_x, over_z, clip3_ff;

   always_comb begin
      shx    = prod_x_ff >>> hpcr_pkg::FRAC_BITS;
      shz    = prod_z_ff >>> hpcr_pkg::FRAC_BITS;
      over_x = (shx > hpcr_pkg::SCALE_LIM) || (shx < hpcr_pkg::SCALE_NEG_LIM);
      over_z = (shz > hpcr_pkg::SCALE_LIM) || (shz < hpcr_pkg::SCALE_NEG_LIM);
      if (shx > hpcr_pkg::SCALE_LIM) begin
         tx_in = hpcr_pkg::SCALE_LIM[hpcr_pkg::SCALE_WIDTH-1:0];
      end else if (shx < hpcr_pkg::SCALE_NEG_LIM) begin
         tx_in = hpcr_pkg::SCALE_NEG_LIM[hpcr_pkg::SCALE_WIDTH-1:0];
      end else begin
         tx_in = shx[hpcr_pkg::SCALE_WIDTH-1:0];
      end
      if (shz > hpcr_pkg::SCALE_LIM) begin
         tz_in = hpcr_pkg::SCALE_LIM[hpcr_pkg::SCALE_WIDTH-1:0];
      end else if (shz < hpcr_pkg::SCALE_NEG_LIM) begin
         tz_in = hpcr_pkg::SCALE_NEG_LIM[hpcr_pkg::SCALE_WIDTH-1:0];
      end else begin
         tz_in = shz[hpcr_pkg::SCALE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[2]) begin
         tx_ff    <= tx_in;
         tz_ff    <= tz_in;
         clip3_ff <= over_x || over_z;
      end
   end

   // stage 4: inverse layout matrix products, floored
   logic signed [hpcr_pkg::SCALE_WIDTH-1:0]    a_k, a_tw, a_t;
   logic signed [hpcr_pkg::MAT_PROD_WIDTH-1:0] mk, mt, mw;
   logic signed [hpcr_pkg::SCALE_WIDTH-1:0]    pk_ff, pt_ff, pw_ff;
   logic                                       clip4_ff;

   always_comb begin
      // pointy: q = k*x - t*z, r = w*z; flat: q = w*x, r = k*z - t*x
      a_k  = (orient_ff == hpcr_pkg::ORIENT_POINTY) ? tx_ff : tz_ff;
      a_tw = (orient_ff == hpcr_pkg::ORIENT_POINTY) ? tz_ff : tx_ff;
      a_t  = a_tw;
      mk   = a_k  * signed'({1'b0, hpcr_pkg::K_SQRT3_3});
      mt   = a_t  * signed'({1'b0, hpcr_pkg::K_THIRD});
      mw   = a_tw * signed'({1'b0, hpcr_pkg::K_TWO_THIRDS});
   end

   always_ff @(posedge clock) begin
      if (stage_adv[3]) begin
         pk_ff    <= mk[hpcr_pkg::FRAC_BITS +: hpcr_pkg::SCALE_WIDTH];
         pt_ff    <= mt[hpcr_pkg::FRAC_BITS +: hpcr_pkg::SCALE_WIDTH];
         pw_ff    <= mw[hpcr_pkg::FRAC_BITS +: hpcr_pkg::SCALE_WIDTH];
         clip4_ff <= clip3_ff;
      end
   end

   // stage 5: fractional cube coordinates and rounding
   logic signed [hpcr_pkg::FRAC_WIDTH-1:0] f_diff, fq, fr, fs;
   hpcr_pkg::round_type                    rq_in, rr_in, rs_in;
   hpcr_pkg::round_type                    rq_ff, rr_ff, rs_ff;
   logic                                   clip5_ff;

   always_comb begin
      f_diff = hpcr_pkg::FRAC_WIDTH'(pk_ff) - hpcr_pkg::FRAC_WIDTH'(pt_ff);
      if (orient_ff == hpcr_pkg::ORIENT_POINTY) begin
         fq = f_diff;
         fr = hpcr_pkg::FRAC_WIDTH'(pw_ff);
      end else begin
         fq = hpcr_pkg::FRAC_WIDTH'(pw_ff);
         fr = f_diff;
      end
      fs = -fq - fr;
   end

   hpcr_round u_round_q (.frac_in(fq), .rnd_out(rq_in));
   hpcr_round u_round_r (.frac_in(fr), .rnd_out(rr_in));
   hpcr_round u_round_s (.frac_in(fs), .rnd_out(rs_in));

   always_ff @(posedge clock) begin
      if (stage_adv[4]) begin
         rq_ff    <= rq_in;
         rr_ff    <= rr_in;
         rs_ff    <= rs_in;
         clip5_ff <= clip4_ff;
      end
   end

   // stage 6: rebuild the worst component, saturate, output register
   logic signed [hpcr_pkg::REBUILD_WIDTH-1:0] q_w, r_w, s_w;
   logic signed [hpcr_pkg::REBUILD_WIDTH-1:0] q_rb, r_rb, s_rb;
   logic signed [hpcr_pkg::COORD_WIDTH-1:0]   cube_q_in, cube_r_in, cube_s_in;
   logic signed [hpcr_pkg::COORD_WIDTH-1:0]   cube_q_ff, cube_r_ff, cube_s_ff;
   logic                                      over_q, over_r, over_s;
   logic                                      clipped_ff;

   always_comb begin
      q_w  = hpcr_pkg::REBUILD_WIDTH'(rq_ff.value);
      r_w  = hpcr_pkg::REBUILD_WIDTH'(rr_ff.value);
      s_w  = hpcr_pkg::REBUILD_WIDTH'(rs_ff.value);
      q_rb = q_w;
      r_rb = r_w;
      s_rb = s_w;
      // strict compares: q first, then r, else s
      if ((rq_ff.err > rr_ff.err) && (rq_ff.err > rs_ff.err)) begin
         q_rb = -r_w - s_w;
      end else if (rr_ff.err > rs_ff.err) begin
         r_rb = -q_w - s_w;
      end else begin
         s_rb = -q_w - r_w;
      end
      over_q = (q_rb > hpcr_pkg::COORD_MAX) || (q_rb < hpcr_pkg::COORD_MIN);
      over_r = (r_rb > hpcr_pkg::COORD_MAX) || (r_rb < hpcr_pkg::COORD_MIN);
      over_s = (s_rb > hpcr_pkg::COORD_MAX) || (s_rb < hpcr_pkg::COORD_MIN);
      if (q_rb > hpcr_pkg::COORD_MAX) begin
         cube_q_in = hpcr_pkg::COORD_MAX[hpcr_pkg::COORD_WIDTH-1:0];
      end else if (q_rb < hpcr_pkg::COORD_MIN) begin
         cube_q_in = hpcr_pkg::COORD_MIN[hpcr_pkg::COORD_WIDTH-1:0];
      end else begin
         cube_q_in = q_rb[hpcr_pkg::COORD_WIDTH-1:0];
      end
      if (r_rb > hpcr_pkg::COORD_MAX) begin
         cube_r_in = hpcr_pkg::COORD_MAX[hpcr_pkg::COORD_WIDTH-1:0];
      end else if (r_rb < hpcr_pkg::COORD_MIN) begin
         cube_r_in = hpcr_pkg::COORD_MIN[hpcr_pkg::COORD_WIDTH-1:0];
      end else begin
         cube_r_in = r_rb[hpcr_pkg::COORD_WIDTH-1:0];
      end
      if (s_rb > hpcr_pkg::COORD_MAX) begin
         cube_s_in = hpcr_pkg::COORD_MAX[hpcr_pkg::COORD_WIDTH-1:0];
      end else if (s_rb < hpcr_pkg::COORD_MIN) begin
         cube_s_in = hpcr_pkg::COORD_MIN[hpcr_pkg::COORD_WIDTH-1:0];
      end else begin
         cube_s_in = s_rb[hpcr_pkg::COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[5]) begin
         cube_q_ff  <= cube_q_in;
         cube_r_ff  <= cube_r_in;
         cube_s_ff  <= cube_s_in;
         clipped_ff <= clip5_ff || over_q || over_r || over_s;
      end
   end

   assign rsp_ch.cube_q  = cube_q_ff;
   assign rsp_ch.cube_r  = cube_r_ff;
   assign rsp_ch.cube_s  = cube_s_ff;
   assign rsp_ch.clipped = clipped_ff;

   // checks
   logic signed [hpcr_pkg::COORD_WIDTH+1:0] out_sum;

   assign out_sum = (hpcr_pkg::COORD_WIDTH+2)'(cube_q_ff)
                  + (hpcr_pkg::COORD_WIDTH+2)'(cube_r_ff)
                  + (hpcr_pkg::COORD_WIDTH+2)'(cube_s_ff);

   `ASSERT_ALWAYS(a_reset_empties, clock, reset |=> (stg_valid_ff == '0))
   `ASSERT_PROP(a_accept_enters, clock, reset, (req_ch.valid && req_ch.ready) |=> stg_valid_ff[0])
   `ASSERT_PROP(a_stall_holds, clock, reset, (stg_valid_ff[2] && !stage_adv[3]) |=> (stg_valid_ff[2] && $stable(tx_ff) && $stable(tz_ff)))
   `ASSERT_PROP(a_scale_range, clock, reset, stg_valid_ff[2] |-> ((tx_ff <= hpcr_pkg::SCALE_LIM) && (tx_ff >= hpcr_pkg::SCALE_NEG_LIM)))
   `ASSERT_PROP(a_err_half, clock, reset, stg_valid_ff[4] |-> ((rq_ff.err <= hpcr_pkg::HALF) && (rr_ff.err <= hpcr_pkg::HALF) && (rs_ff.err <= hpcr_pkg::HALF)))
   `ASSERT_PROP(a_cube_sum, clock, reset, (rsp_ch.valid && !clipped_ff) |-> (out_sum == '0))

endmodule
